// ===== rtl/core/rcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpd_pkg
// Types, constants and helper functions shared by the robot command packet
// decoder.
// ----------------------------------------------------------------------------
package rcpd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RNUM_W  = 4;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned HDR_BYTES  = 3;
  localparam int unsigned SLOT_BYTES = 4;

  localparam logic [POS_W-1:0]  POS_MAX    = 5'd31;
  localparam logic [POS_W-1:0]  HIGH_BASE  = 5'd18;
  localparam logic [POS_W-1:0]  KICK_BASE  = 5'd22;
  localparam logic [SLOT_W-1:0] SLOT_NONE  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_1     = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_2     = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_3     = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_4     = 3'd4;

  localparam logic [BYTE_W-1:0] KICK_RAW_MAX = 8'd127;
  localparam logic [BYTE_W-1:0] KICK_MAPPED  = 8'd150;

  localparam logic STATUS_DECODED  = 1'b0;
  localparam logic STATUS_NOT_ADDR = 1'b1;

  typedef enum logic [1:0] {
    PT_NEW      = 2'd0,
    PT_LEGACY   = 2'd1,
    PT_FREQ     = 2'd2,
    PT_NONE     = 2'd3
  } ptype_e;

  typedef enum logic [1:0] {
    HC_NEW      = 2'd0,
    HC_LEGACY   = 2'd1,
    HC_NONE     = 2'd2,
    HC_FREQ     = 2'd3
  } hdr_code_e;

  typedef struct packed {
    logic [1:0]        code;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] ctrl;
    logic [BYTE_W-1:0] sx;
    logic [BYTE_W-1:0] sy;
    logic [BYTE_W-1:0] rot;
    logic [BYTE_W-1:0] high;
    logic [BYTE_W-1:0] kick;
  } snap_t;

  function automatic logic [1:0] map_ptype(input logic [1:0] code);
    logic [1:0] res;
    unique case (hdr_code_e'(code))
      HC_NEW:    res = PT_NEW;
      HC_LEGACY: res = PT_LEGACY;
      HC_FREQ:   res = PT_FREQ;
      HC_NONE:   res = PT_NONE;
      default:   res = PT_NONE;
    endcase
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] map_kick(input logic [BYTE_W-1:0] raw);
    return (raw == KICK_RAW_MAX) ? KICK_MAPPED : raw;
  endfunction

endpackage

// ===== rtl/core/rcpd_if.sv =====
// ----------------------------------------------------------------------------
// rcpd_if
// Valid/ready channels of the robot command packet decoder: received bytes
// in, decoded commands out.
// ----------------------------------------------------------------------------
interface rcpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rcpd_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [1:0]         packet_type;
  logic signed [2:0]  dribbler_level;
  logic [7:0]         chip_strength;
  logic [7:0]         shoot_strength;
  logic signed [9:0]  speed_x;
  logic signed [9:0]  speed_y;
  logic signed [11:0] speed_rotation;

  modport source (
    output valid, output status, output packet_type, output dribbler_level,
    output chip_strength, output shoot_strength, output speed_x, output speed_y,
    output speed_rotation, input ready
  );
  modport sink (
    input valid, input status, input packet_type, input dribbler_level,
    input chip_strength, input shoot_strength, input speed_x, input speed_y,
    input speed_rotation, output ready
  );
endinterface

// ===== rtl/core/rcpd_capture.sv =====
// ----------------------------------------------------------------------------
// rcpd_capture
// Tracks the byte position, captures header, slot, high-bits and kick bytes
// and hands a snapshot of them to the decoder on the last byte.
// ----------------------------------------------------------------------------
module rcpd_capture (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rcpd_pkg::RNUM_W-1:0] rnum_i,
  rcpd_in_if.sink                     in_i,
  input  logic                        take_i,
  output logic                        snap_valid_o,
  output rcpd_pkg::snap_t             snap_o
);
  import rcpd_pkg::*;

  logic [POS_W-1:0]  pos_q;
  logic [BYTE_W-1:0] hdr_q  [HDR_BYTES];
  logic [BYTE_W-1:0] hdr_d  [HDR_BYTES];
  logic [BYTE_W-1:0] slot_q [SLOT_BYTES];
  logic [BYTE_W-1:0] slot_d [SLOT_BYTES];
  logic [BYTE_W-1:0] high_q, high_d;
  logic [BYTE_W-1:0] kick_q, kick_d;
  logic [SLOT_W-1:0] sel;
  logic [POS_W:0]    pos_p1;
  logic              acc;
  logic              snap_valid_q;
  snap_t             snap_q;

  assign acc          = in_i.valid && in_i.ready;
  assign in_i.ready   = !snap_valid_q || take_i;
  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;
  assign pos_p1       = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};

  always_comb begin
    hdr_d = hdr_q;
    if (pos_q < POS_W'(HDR_BYTES)) begin
      hdr_d[pos_q[1:0]] = in_i.data_byte;
    end
  end

  always_comb begin
    priority if (hdr_d[1][7:4] == rnum_i) begin
      sel = SLOT_1;
    end else if (hdr_d[1][3:0] == rnum_i) begin
      sel = SLOT_2;
    end else if (hdr_d[2][7:4] == rnum_i) begin
      sel = SLOT_3;
    end else if (hdr_d[2][3:0] == rnum_i) begin
      sel = SLOT_4;
    end else begin
      sel = SLOT_NONE;
    end
  end

  always_comb begin
    slot_d = slot_q;
    high_d = high_q;
    kick_d = kick_q;
    if (sel != SLOT_NONE) begin
      if (pos_p1[POS_W:2] == {1'b0, sel}) begin
        slot_d[pos_p1[1:0]] = in_i.data_byte;
      end
      if (pos_q == HIGH_BASE + {2'b00, sel}) begin
        high_d = in_i.data_byte;
      end
      if (pos_q == KICK_BASE + {2'b00, sel}) begin
        kick_d = in_i.data_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      hdr_q        <= '{default: '0};
      slot_q       <= '{default: '0};
      high_q       <= '0;
      kick_q       <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      if (acc && in_i.last_byte) begin
        pos_q  <= '0;
        hdr_q  <= '{default: '0};
        slot_q <= '{default: '0};
        high_q <= '0;
        kick_q <= '0;
      end else if (acc) begin
        if (pos_q != POS_MAX) begin
          pos_q <= pos_q + 1'b1;
        end
        hdr_q  <= hdr_d;
        slot_q <= slot_d;
        high_q <= high_d;
        kick_q <= kick_d;
      end
      if (acc && in_i.last_byte) begin
        snap_valid_q <= 1'b1;
      end else if (take_i) begin
        snap_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_i.last_byte) begin
      snap_q.code <= hdr_d[0][7:6];
      snap_q.slot <= sel;
      snap_q.ctrl <= slot_d[0];
      snap_q.sx   <= slot_d[1];
      snap_q.sy   <= slot_d[2];
      snap_q.rot  <= slot_d[3];
      snap_q.high <= high_d;
      snap_q.kick <= kick_d;
    end
  end

`ifndef SYNTHESIS
  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.last_byte |=> pos_q == '0 && hdr_q[0] == '0)
    else $error("position not cleared after last item");
  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_q && !take_i |=> snap_valid_q && $stable(snap_q))
    else $error("pending snapshot lost or changed");
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_q && !take_i |-> !in_i.ready)
    else $error("item taken while snapshot blocked");
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == POS_MAX && acc && !in_i.last_byte |=> pos_q == POS_MAX)
    else $error("position did not saturate");
`endif

endmodule

// ===== rtl/core/rcpd_decode.sv =====
// ----------------------------------------------------------------------------
// rcpd_decode
// Decodes a captured packet into the held command and presents it as the
// result item; the held registers double as the result register.
// ----------------------------------------------------------------------------
module rcpd_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            snap_valid_i,
  input  rcpd_pkg::snap_t snap_i,
  output logic            take_o,
  rcpd_out_if.source      out_o
);
  import rcpd_pkg::*;

  logic               valid_q;
  logic               status_q;
  logic [1:0]         ptype_q;
  logic signed [2:0]  drib_q, drib_d;
  logic [BYTE_W-1:0]  chip_q, shoot_q, kick;
  logic signed [9:0]  sx_q, sx_d, sy_q, sy_d;
  logic signed [11:0] rot_q, rot_d;
  logic [8:0]         mag_x, mag_y;
  logic [10:0]        mag_r;
  logic               free, load, hit;

  assign free   = !valid_q || out_o.ready;
  assign load   = snap_valid_i && free;
  assign take_o = free;
  assign hit    = snap_i.slot != SLOT_NONE;

  assign kick  = map_kick(snap_i.kick);
  assign mag_x = {snap_i.high[7:6], snap_i.sx[6:0]};
  assign mag_y = {snap_i.high[5:4], snap_i.sy[6:0]};
  assign mag_r = {snap_i.high[3:0], snap_i.rot[6:0]};

  always_comb begin
    drib_d = snap_i.ctrl[7] ? -$signed({1'b0, snap_i.ctrl[5:4]})
                            :  $signed({1'b0, snap_i.ctrl[5:4]});
    sx_d   = snap_i.sx[7]   ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    sy_d   = snap_i.sy[7]   ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
    rot_d  = snap_i.rot[7]  ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      status_q <= STATUS_DECODED;
      ptype_q  <= PT_NEW;
      drib_q   <= '0;
      chip_q   <= '0;
      shoot_q  <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      rot_q    <= '0;
    end else begin
      if (free) begin
        valid_q <= snap_valid_i;
      end
      if (load) begin
        status_q <= hit ? STATUS_DECODED : STATUS_NOT_ADDR;
        ptype_q  <= map_ptype(snap_i.code);
        if (hit) begin
          drib_q <= drib_d;
          sx_q   <= sx_d;
          sy_q   <= sy_d;
          rot_q  <= rot_d;
          if (snap_i.ctrl[6]) begin
            chip_q <= kick;
          end else begin
            shoot_q <= kick;
          end
        end
      end
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.status         = status_q;
  assign out_o.packet_type    = ptype_q;
  assign out_o.dribbler_level = drib_q;
  assign out_o.chip_strength  = chip_q;
  assign out_o.shoot_strength = shoot_q;
  assign out_o.speed_x        = sx_q;
  assign out_o.speed_y        = sy_q;
  assign out_o.speed_rotation = rot_q;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_o.ready |=> valid_q && $stable(sx_q) && $stable(chip_q)
                                && $stable(status_q))
    else $error("stalled result changed");
  a_miss_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !hit |=> status_q == STATUS_NOT_ADDR && $stable(sx_q) && $stable(rot_q)
                     && $stable(drib_q) && $stable(chip_q) && $stable(shoot_q))
    else $error("held command changed on unaddressed packet");
  a_one_kick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $stable(chip_q) || $stable(shoot_q))
    else $error("chip and shoot updated together");
`endif

endmodule

// ===== rtl/core/robot_command_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// robot_command_packet_decoder
// Decodes radio command packets, one byte per item, into this robot's
// dribbler, kick and speed command.
//
//   channel   dir  payload                                   handshake
//   in_i      in   data_byte, last_byte                      valid/ready
//   out_o     out  status, packet_type, dribbler, kicks,     valid/ready
//                  speed_x, speed_y, speed_rotation
//   cfg       in   cfg_wdata_i (robot number)                cfg_we_i
//
// One byte is taken every cycle unless input stalls. A last byte is snapshot
// when accepted and decoded into the held-command register once it is free.
// Reset clears the position, capture bytes, held command and robot number.
// A stalled result holds the snapshot stage; input stalls once both the
// snapshot and the result register are full.
// ----------------------------------------------------------------------------
module robot_command_packet_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rcpd_pkg::RNUM_W-1:0] cfg_wdata_i,
  rcpd_in_if.sink                     in_i,
  rcpd_out_if.source                  out_o
);
  import rcpd_pkg::*;

  logic [RNUM_W-1:0] rnum_q;
  logic              snap_valid, take;
  snap_t             snap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnum_q <= '0;
    end else if (cfg_we_i) begin
      rnum_q <= cfg_wdata_i;
    end
  end

  rcpd_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rnum_i       (rnum_q),
    .in_i         (in_i),
    .take_i       (take),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  rcpd_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .take_o       (take),
    .out_o        (out_o)
  );

endmodule

// ===== sim/tb_robot_command_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_robot_command_packet_decoder
// Self-checking bench for the robot command packet decoder. A short table of
// hand-made packets is followed by random packets under several robot ids.
// Every decoded command is compared with the table's expected value or with
// a model of the decoder kept in the bench, with random gaps on both channels
// and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_robot_command_packet_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import rcpd_pkg::*;

  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 5;

  typedef struct packed {
    logic              status;
    ptype_e            ptype;
    logic signed [2:0] drib;
    logic [7:0]        chip;
    logic [7:0]        shoot;
    logic signed [9:0] sx;
    logic signed [9:0] sy;
    logic signed [11:0] rot;
  } cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    cmd_t       want;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  rcpd_in_if  rx_bytes ();
  rcpd_out_if cmd_out ();

  robot_command_packet_decoder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (rx_bytes),
    .out_o       (cmd_out)
  );

  // decoder state as the bench sees it
  logic [3:0]         robot_id;
  logic [4:0]         pos_m;
  logic [7:0]         hdr_m [3];
  logic [2:0]         slot_m;
  logic [7:0]         slotb_m [4];
  logic [7:0]         hi_m;
  logic [7:0]         kick_m;
  logic signed [2:0]  drib_m;
  logic signed [9:0]  sx_m;
  logic signed [9:0]  sy_m;
  logic signed [11:0] rot_m;
  logic [7:0]         chip_m;
  logic [7:0]         shoot_m;

  cmd_t      pending_cmds [$];
  stim_row_t stim_tab [$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  cmds_expected = 0;
  int  cmds_checked = 0;
  int  unaddressed = 0;
  int  in_idle_pct = 25;
  int  out_idle_pct = 25;
  logic hold_active;
  event hold_go;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("timeout at %0t", $time);
    $display("robot_command_packet_decoder verification failed");
    $finish;
  end

  function automatic cmd_t mk_cmd(input logic st, input ptype_e pt,
                                  input logic signed [2:0] dr,
                                  input logic [7:0] ch, input logic [7:0] sh,
                                  input logic signed [9:0] x,
                                  input logic signed [9:0] y,
                                  input logic signed [11:0] r);
    cmd_t c;
    c.status = st;
    c.ptype  = pt;
    c.drib   = dr;
    c.chip   = ch;
    c.shoot  = sh;
    c.sx     = x;
    c.sy     = y;
    c.rot    = r;
    return c;
  endfunction

  function automatic logic [2:0] match_slot();
    if (hdr_m[1][7:4] == robot_id) return SLOT_1;
    if (hdr_m[1][3:0] == robot_id) return SLOT_2;
    if (hdr_m[2][7:4] == robot_id) return SLOT_3;
    if (hdr_m[2][3:0] == robot_id) return SLOT_4;
    return SLOT_NONE;
  endfunction

  function automatic logic signed [11:0] apply_sign(input logic neg,
                                                    input logic [10:0] mag);
    logic signed [11:0] v;
    v = {1'b0, mag};
    return neg ? -v : v;
  endfunction

  task automatic track_byte(input logic [7:0] d, input logic l,
                            output bit made, output cmd_t c);
    int p;
    int base;
    logic [7:0] ctrl;
    logic [7:0] kick;
    logic signed [2:0] dv;
    logic signed [11:0] v;
    p = pos_m;
    made = 1'b0;
    c = '0;
    if (p < 3) hdr_m[p] = d;
    slot_m = match_slot();
    if (slot_m != SLOT_NONE) begin
      base = 4 * int'(slot_m) - 1;
      if (p >= base && p < base + 4) slotb_m[p - base] = d;
      if (p == int'(HIGH_BASE) + int'(slot_m)) hi_m = d;
      if (p == int'(KICK_BASE) + int'(slot_m)) kick_m = d;
    end
    if (pos_m < POS_MAX) pos_m = pos_m + 5'd1;
    if (l) begin
      made = 1'b1;
      if (slot_m != SLOT_NONE) begin
        ctrl = slotb_m[0];
        kick = (kick_m == KICK_RAW_MAX) ? KICK_MAPPED : kick_m;
        dv = {1'b0, ctrl[5:4]};
        drib_m = ctrl[7] ? -dv : dv;
        if (ctrl[6]) chip_m = kick;
        else shoot_m = kick;
        v = apply_sign(slotb_m[1][7], {2'b00, hi_m[7:6], slotb_m[1][6:0]});
        sx_m = v[9:0];
        v = apply_sign(slotb_m[2][7], {2'b00, hi_m[5:4], slotb_m[2][6:0]});
        sy_m = v[9:0];
        rot_m = apply_sign(slotb_m[3][7], {hi_m[3:0], slotb_m[3][6:0]});
        c.status = STATUS_DECODED;
      end else begin
        c.status = STATUS_NOT_ADDR;
        unaddressed++;
      end
      case (hdr_m[0][7:6])
        2'd0:    c.ptype = PT_NEW;
        2'd1:    c.ptype = PT_LEGACY;
        2'd3:    c.ptype = PT_FREQ;
        default: c.ptype = PT_NONE;
      endcase
      c.drib  = drib_m;
      c.chip  = chip_m;
      c.shoot = shoot_m;
      c.sx    = sx_m;
      c.sy    = sy_m;
      c.rot   = rot_m;
      pos_m  = '0;
      slot_m = SLOT_NONE;
      hi_m   = '0;
      kick_m = '0;
      for (int i = 0; i < 3; i++) hdr_m[i] = '0;
      for (int i = 0; i < 4; i++) slotb_m[i] = '0;
    end
  endtask

  task automatic send_byte(input logic [7:0] d, input logic l, input bit typed,
                           input cmd_t want);
    cmd_t pred;
    bit made;
    while ($urandom_range(99) < in_idle_pct) begin
      rx_bytes.valid <= 1'b0;
      @(posedge clk);
    end
    rx_bytes.valid     <= 1'b1;
    rx_bytes.data_byte <= d;
    rx_bytes.last_byte <= l;
    @(posedge clk);
    while (!rx_bytes.ready) @(posedge clk);
    track_byte(d, l, made, pred);
    if (made) begin
      pending_cmds.push_back(typed ? want : pred);
      cmds_expected++;
    end
    bytes_sent++;
  endtask

  task automatic add_row(input logic [7:0] d, input logic l, input bit typed,
                         input cmd_t want);
    stim_row_t r;
    r.data  = d;
    r.last  = l;
    r.typed = typed;
    r.want  = want;
    stim_tab.push_back(r);
  endtask

  task automatic drain_results();
    rx_bytes.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_robot_id(input logic [3:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    robot_id = v;
  endtask

  task automatic send_random_packet();
    logic [7:0] pkt [40];
    logic [3:0] nib [1:4];
    int len;
    int roll;
    int pick;
    roll = $urandom_range(99);
    for (int i = 0; i < 40; i++) begin
      pkt[i] = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0:       pkt[i] = 8'h00;
          1:       pkt[i] = 8'hFF;
          2:       pkt[i] = 8'h80;
          default: pkt[i] = 8'h7F;
        endcase
      end
    end
    if (roll < 15) begin
      len = $urandom_range(1, 40);
    end else begin
      if (roll < 45) len = $urandom_range(1, 23);
      else if (roll < 85) len = $urandom_range(24, 27);
      else len = $urandom_range(28, 34);
      pick = $urandom_range(0, 4);
      // make earlier nibbles miss so the intended slot wins
      for (int k = 1; k <= 4; k++) begin
        if (k == pick) nib[k] = robot_id;
        else if (k < pick || pick == 0) nib[k] = robot_id + 4'($urandom_range(1, 15));
        else nib[k] = 4'($urandom_range(15));
      end
      pkt[1] = {nib[1], nib[2]};
      pkt[2] = {nib[3], nib[4]};
      if (pick != 0 && $urandom_range(2) == 0) pkt[22 + pick] = KICK_RAW_MAX;
    end
    for (int i = 0; i < len; i++) send_byte(pkt[i], i == len - 1, 1'b0, '0);
  endtask

  initial begin
    hold_active = 1'b0;
    forever begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  initial begin
    cmd_t want;
    cmd_t seen;
    cmd_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && cmd_out.valid && cmd_out.ready) begin
        seen.status = cmd_out.status;
        seen.ptype  = ptype_e'(cmd_out.packet_type);
        seen.drib   = cmd_out.dribbler_level;
        seen.chip   = cmd_out.chip_strength;
        seen.shoot  = cmd_out.shoot_strength;
        seen.sx     = cmd_out.speed_x;
        seen.sy     = cmd_out.speed_y;
        seen.rot    = cmd_out.speed_rotation;
        if (pending_cmds.size() == 0) begin
          errors++;
          $display("[%0t] unexpected command, status %0d type %0d", $time,
                   seen.status, seen.ptype);
        end else begin
          want = pending_cmds.pop_front();
          cmds_checked++;
          if (seen !== want) begin
            errors++;
            $display("[%0t] command mismatch", $time);
            $display("  expected st %0d pt %0d dr %0d chip %0d shoot %0d x %0d y %0d r %0d",
                     want.status, want.ptype, want.drib, want.chip, want.shoot,
                     want.sx, want.sy, want.rot);
            $display("  actual   st %0d pt %0d dr %0d chip %0d shoot %0d x %0d y %0d r %0d",
                     seen.status, seen.ptype, seen.drib, seen.chip, seen.shoot,
                     seen.sx, seen.sy, seen.rot);
          end
        end
      end
      cmd_out.ready <= !hold_active && ($urandom_range(99) >= out_idle_pct);
    end
  end

  initial begin
    int phase_bytes;
    int phase_cmds;
    int n;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    rx_bytes.valid     = 1'b0;
    rx_bytes.data_byte = '0;
    rx_bytes.last_byte = 1'b0;
    robot_id = '0;
    pos_m    = '0;
    slot_m   = SLOT_NONE;
    hi_m     = '0;
    kick_m   = '0;
    drib_m   = '0;
    sx_m     = '0;
    sy_m     = '0;
    rot_m    = '0;
    chip_m   = '0;
    shoot_m  = '0;
    for (int i = 0; i < 3; i++) hdr_m[i] = '0;
    for (int i = 0; i < 4; i++) slotb_m[i] = '0;

    // one-byte frequency-test packet straight after reset
    add_row(8'hC0, 1'b1, 1'b1,
            mk_cmd(STATUS_DECODED, PT_FREQ, 3'sd0, 8'd0, 8'd0, 10'sd0, 10'sd0, 12'sd0));
    // no nibble matches robot id 0
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h12, 1'b0, 1'b0, '0);
    add_row(8'h34, 1'b1, 1'b1,
            mk_cmd(STATUS_NOT_ADDR, PT_NEW, 3'sd0, 8'd0, 8'd0, 10'sd0, 10'sd0, 12'sd0));
    // full slot 1 at negative extremes, kick 127, run past the end
    add_row(8'h40, 1'b0, 1'b0, '0);
    add_row(8'h0F, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hB0, 1'b0, 1'b0, '0);
    for (int i = 4; i <= 6; i++) add_row(8'hFF, 1'b0, 1'b0, '0);
    for (int i = 7; i <= 18; i++) add_row(8'h5A, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    for (int i = 20; i <= 22; i++) add_row(8'hA5, 1'b0, 1'b0, '0);
    add_row(KICK_RAW_MAX, 1'b0, 1'b0, '0);
    for (int i = 24; i <= 26; i++) add_row(8'h3C, 1'b0, 1'b0, '0);
    add_row(8'hC3, 1'b1, 1'b1,
            mk_cmd(STATUS_DECODED, PT_LEGACY, -3'sd3, 8'd0, 8'd150,
                   -10'sd511, -10'sd511, -12'sd2047));
    // short packet with signed zeros and a chip kick
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hC0, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b1, 1'b1,
            mk_cmd(STATUS_DECODED, PT_NONE, 3'sd0, 8'd0, 8'd150, 10'sd0, 10'sd0, 12'sd0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_tab[i])
      send_byte(stim_tab[i].data, stim_tab[i].last, stim_tab[i].typed, stim_tab[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      if (ph == 0) write_robot_id(4'hF);
      else if (ph == 1) write_robot_id(4'h0);
      else write_robot_id(4'($urandom_range(15)));
      in_idle_pct = (ph == 1) ? 0 : 25;
      out_idle_pct <= (ph == 1) ? 0 : 25;
      if (ph == 2) begin
        // hold the result side while short packets keep arriving
        -> hold_go;
        in_idle_pct = 0;
        repeat (6) begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(255)), i == n - 1, 1'b0, '0);
        end
        in_idle_pct = 25;
      end
      phase_bytes = bytes_sent;
      phase_cmds  = cmds_expected;
      while (bytes_sent - phase_bytes < 64 || cmds_expected - phase_cmds < 3) begin
        send_random_packet();
        if ($urandom_range(19) == 0) drain_results();
      end
    end
    drain_results();

    $display("covered %0d bytes and %0d decoded commands, %0d of them unaddressed,",
             bytes_sent, cmds_checked, unaddressed);
    $display("over %0d robot id settings including 0 and 15, with a result-side hold-off",
             PHASES + 1);
    if (errors == 0) begin
      $display("robot_command_packet_decoder verification clean");
    end else begin
      $display("robot_command_packet_decoder verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rcpd_pkg.sv
rtl/core/rcpd_if.sv
rtl/core/rcpd_capture.sv
rtl/core/rcpd_decode.sv
rtl/core/robot_command_packet_decoder.sv
sim/tb_robot_command_packet_decoder.sv
